FILE: rtl/psc_pkg.sv
// ----------------------------------------------------------------------------
// psc_pkg
// Shared widths, codes, register indexes and types of the power state
// controller.
// ----------------------------------------------------------------------------
package psc_pkg;

   localparam int NOW_W   = 32;
   localparam int DEB_W   = 16;
   localparam int IDLE_W  = 11;
   localparam int MV_W    = 13;
   localparam int LIMIT_W = 27;
   localparam int CODE_W  = 2;

   localparam logic [LIMIT_W-1:0] MS_PER_MIN = 27'd60000;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_DEBOUNCE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_MIN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CUTOFF      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CHARGE_ONLY = 2'd3;

   localparam logic [DEB_W-1:0]   DEBOUNCE_RST    = 16'd500;
   localparam logic [LIMIT_W-1:0] IDLE_LIMIT_RST  = 27'd600000;
   localparam logic [MV_W-1:0]    CUTOFF_RST      = 13'd3300;
   localparam logic               CHARGE_ONLY_RST = 1'b1;

   // stream widths
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 8;

   // operations
   localparam logic OP_BOOT = 1'b0;
   localparam logic OP_POLL = 1'b1;

   // reported power state
   localparam logic [CODE_W-1:0] STATE_RUN     = 2'd0;
   localparam logic [CODE_W-1:0] STATE_CHARGE  = 2'd1;
   localparam logic [CODE_W-1:0] STATE_BATWAIT = 2'd2;
   localparam logic [CODE_W-1:0] STATE_SLEEP   = 2'd3;

   // actions
   localparam logic [CODE_W-1:0] ACT_NONE  = 2'd0;
   localparam logic [CODE_W-1:0] ACT_OFF   = 2'd1;
   localparam logic [CODE_W-1:0] ACT_HOLD  = 2'd2;
   localparam logic [CODE_W-1:0] ACT_RESET = 2'd3;

   // sleep reasons
   localparam logic [CODE_W-1:0] WHY_NONE     = 2'd0;
   localparam logic [CODE_W-1:0] WHY_BOOT_LOW = 2'd1;
   localparam logic [CODE_W-1:0] WHY_CUTOFF   = 2'd2;
   localparam logic [CODE_W-1:0] WHY_IDLE     = 2'd3;

   typedef enum logic [3:0] {
      MODE_RUNNING = 4'b0001,
      MODE_CHARGE  = 4'b0010,
      MODE_BATWAIT = 4'b0100,
      MODE_SLEEP   = 4'b1000
   } mode_type;

   typedef struct packed {
      logic [DEB_W-1:0]   debounce_ms;
      logic [LIMIT_W-1:0] idle_limit_ms;
      logic [MV_W-1:0]    cutoff_mv;
      logic               charge_only_enable;
   } cfg_type;

   typedef struct packed {
      logic             operation;
      logic [NOW_W-1:0] now_ms;
      logic             switch_on;
      logic             usb_present;
      logic             cutoff_requested;
      logic             client_subscribed;
      logic [MV_W-1:0]  battery_mv;
   } item_type;

   typedef struct packed {
      mode_type         mode;
      logic [NOW_W-1:0] switch_off_start;
      logic             switch_off_armed;
      logic [NOW_W-1:0] idle_start;
      logic             idle_armed;
   } state_type;

   typedef struct packed {
      logic [CODE_W-1:0] power_state;
      logic [CODE_W-1:0] action;
      logic [CODE_W-1:0] sleep_reason;
   } result_type;

endpackage

FILE: rtl/power_state_controller_core.sv
// ----------------------------------------------------------------------------
// power_state_controller_core
// Four-state power controller: boot evaluation and update polls in, one
// state, action and sleep reason out per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one beat per boot evaluation or update poll; req_tuser
//   gives the operation (0 boot, 1 poll), req_tdata the timestamp and the
//   sensed signals. rsp_* returns exactly one beat per request with the
//   power state, action code and sleep reason.
//   csr_* writes the configuration; write only while no beat is in flight.
//   A beat accepted on req_* passes the input register, then the result
//   register, before it is offered on rsp_*. Throughput: one beat per
//   cycle while rsp_* does not stall, set by the single-pass next-state
//   logic between the two registers.
//   Reset (synchronous) empties both registers, restores the configuration
//   defaults and puts the controller in running with both timers disarmed.
//   When rsp_tready is low the result register holds, the input register
//   holds its beat, and req_tready drops once both are full.
// ----------------------------------------------------------------------------
module power_state_controller_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // request stream
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [31:0] now_ms, [32] switch_on, [33] usb_present, [34] cutoff_requested,
   // [35] client_subscribed, [48:36] battery_mv, [55:49] zero
   input  logic [psc_pkg::REQ_TDATA_W-1:0]      req_tdata,
   // [0] operation
   input  logic                                 req_tuser,
   // response stream
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [1:0] power_state, [3:2] action, [5:4] sleep_reason, [7:6] zero
   output logic [psc_pkg::RSP_TDATA_W-1:0]      rsp_tdata,
   // configuration
   input  logic                                 csr_we,
   input  logic [psc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [psc_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   psc_pkg::cfg_type    cfg;
   psc_pkg::item_type   req_item;
   psc_pkg::item_type   s1_item_ff, s1_item_in;
   logic                s1_valid_ff, s1_valid_in;
   psc_pkg::state_type  state_ff, state_in;
   psc_pkg::state_type  state_nxt;
   psc_pkg::result_type eval_res;
   psc_pkg::result_type out_res_ff, out_res_in;
   logic                out_valid_ff, out_valid_in;
   logic                advance;
   logic                accept;

   psc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   psc_eval u_eval (
      .item (s1_item_ff),
      .cur  (state_ff),
      .cfg  (cfg),
      .nxt  (state_nxt),
      .res  (eval_res)
   );

   always_comb begin
      req_item.operation         = req_tuser;
      req_item.now_ms            = req_tdata[31:0];
      req_item.switch_on         = req_tdata[32];
      req_item.usb_present       = req_tdata[33];
      req_item.cutoff_requested  = req_tdata[34];
      req_item.client_subscribed = req_tdata[35];
      req_item.battery_mv        = req_tdata[48:36];
   end

   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      s1_item_in   = accept ? req_item : s1_item_ff;
      s1_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_res_in   = advance ? eval_res : out_res_ff;
      out_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
      state_in     = advance ? state_nxt : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff               <= 1'b0;
         out_valid_ff              <= 1'b0;
         state_ff.mode             <= psc_pkg::MODE_RUNNING;
         state_ff.switch_off_start <= '0;
         state_ff.switch_off_armed <= 1'b0;
         state_ff.idle_start       <= '0;
         state_ff.idle_armed       <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {2'b00, out_res_ff.sleep_reason, out_res_ff.action,
                        out_res_ff.power_state};

   // a sleep reason only comes with a power-off into deep sleep
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_res_ff.sleep_reason != psc_pkg::WHY_NONE)) |->
      ((out_res_ff.power_state == psc_pkg::STATE_SLEEP) &&
       (out_res_ff.action == psc_pkg::ACT_OFF)))
      else $error("sleep reason without power-off into deep sleep");

   // peripherals are held off only on leaving running for wait or charge
   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_res_ff.action == psc_pkg::ACT_HOLD)) |->
      ((out_res_ff.power_state == psc_pkg::STATE_BATWAIT) ||
       (out_res_ff.power_state == psc_pkg::STATE_CHARGE)))
      else $error("hold action in unexpected state");

   // a boot beat leaves both timers disarmed
   assert property (@(posedge clock) disable iff (reset)
      (advance && (s1_item_ff.operation == psc_pkg::OP_BOOT)) |=>
      (!state_ff.switch_off_armed && !state_ff.idle_armed))
      else $error("timer armed after boot");

   // a stalled input beat is kept and the controller state does not move
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=>
      (s1_valid_ff && $stable(s1_item_ff) && $stable(state_ff)))
      else $error("input register lost a stalled beat");

endmodule

FILE: rtl/psc_csr.sv
// ----------------------------------------------------------------------------
// psc_csr
// Configuration registers; the idle timeout is held pre-scaled to ms.
// ----------------------------------------------------------------------------
module psc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [psc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [psc_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output psc_pkg::cfg_type                    cfg
);

   psc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            psc_pkg::CSR_DEBOUNCE: begin
               cfg_in.debounce_ms = csr_wdata[psc_pkg::DEB_W-1:0];
            end
            psc_pkg::CSR_IDLE_MIN: begin
               cfg_in.idle_limit_ms =
                  psc_pkg::LIMIT_W'(csr_wdata[psc_pkg::IDLE_W-1:0]) * psc_pkg::MS_PER_MIN;
            end
            psc_pkg::CSR_CUTOFF: begin
               cfg_in.cutoff_mv = csr_wdata[psc_pkg::MV_W-1:0];
            end
            psc_pkg::CSR_CHARGE_ONLY: begin
               cfg_in.charge_only_enable = csr_wdata[0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms        <= psc_pkg::DEBOUNCE_RST;
         cfg_ff.idle_limit_ms      <= psc_pkg::IDLE_LIMIT_RST;
         cfg_ff.cutoff_mv          <= psc_pkg::CUTOFF_RST;
         cfg_ff.charge_only_enable <= psc_pkg::CHARGE_ONLY_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: rtl/psc_eval.sv
// ----------------------------------------------------------------------------
// psc_eval
// Next-state and result logic for one registered item.
// ----------------------------------------------------------------------------
module psc_eval (
   input  psc_pkg::item_type   item,
   input  psc_pkg::state_type  cur,
   input  psc_pkg::cfg_type    cfg,
   output psc_pkg::state_type  nxt,
   output psc_pkg::result_type res
);

   logic [psc_pkg::NOW_W-1:0] sw_base;
   logic [psc_pkg::NOW_W-1:0] sw_elapsed;
   logic [psc_pkg::NOW_W-1:0] idle_base;
   logic [psc_pkg::NOW_W-1:0] idle_elapsed;
   logic                      sw_counts_on;
   logic                      idle_hit;

   // an unarmed timer starts now, so its elapsed time is zero
   assign sw_base      = cur.switch_off_armed ? cur.switch_off_start : item.now_ms;
   assign sw_elapsed   = item.now_ms - sw_base;
   assign sw_counts_on = item.switch_on ||
                         (sw_elapsed < psc_pkg::NOW_W'(cfg.debounce_ms));

   assign idle_base    = cur.idle_armed ? cur.idle_start : item.now_ms;
   assign idle_elapsed = item.now_ms - idle_base;
   assign idle_hit     = idle_elapsed >= psc_pkg::NOW_W'(cfg.idle_limit_ms);

   always_comb begin
      nxt              = cur;
      res.action       = psc_pkg::ACT_NONE;
      res.sleep_reason = psc_pkg::WHY_NONE;

      if (item.operation == psc_pkg::OP_BOOT) begin
         nxt.switch_off_armed = 1'b0;
         nxt.switch_off_start = '0;
         nxt.idle_armed       = 1'b0;
         nxt.idle_start       = '0;
         if (!item.switch_on) begin
            nxt.mode = psc_pkg::MODE_BATWAIT;
         end else if (!item.usb_present && (item.battery_mv < cfg.cutoff_mv)) begin
            nxt.mode         = psc_pkg::MODE_SLEEP;
            res.action       = psc_pkg::ACT_OFF;
            res.sleep_reason = psc_pkg::WHY_BOOT_LOW;
         end else if (item.usb_present && cfg.charge_only_enable) begin
            nxt.mode = psc_pkg::MODE_CHARGE;
         end else begin
            nxt.mode = psc_pkg::MODE_RUNNING;
         end
      end else begin
         case (cur.mode)
            psc_pkg::MODE_RUNNING: begin
               if (item.cutoff_requested && !item.usb_present) begin
                  nxt.mode         = psc_pkg::MODE_SLEEP;
                  res.action       = psc_pkg::ACT_OFF;
                  res.sleep_reason = psc_pkg::WHY_CUTOFF;
               end else begin
                  nxt.switch_off_armed = !item.switch_on;
                  nxt.switch_off_start = item.switch_on ? '0 : sw_base;
                  if (!sw_counts_on) begin
                     nxt.mode   = psc_pkg::MODE_BATWAIT;
                     res.action = psc_pkg::ACT_HOLD;
                  end else if (cfg.charge_only_enable && item.usb_present) begin
                     nxt.mode   = psc_pkg::MODE_CHARGE;
                     res.action = psc_pkg::ACT_HOLD;
                  end else if (item.client_subscribed || item.usb_present) begin
                     nxt.idle_armed = 1'b0;
                     nxt.idle_start = '0;
                  end else begin
                     nxt.idle_armed = 1'b1;
                     nxt.idle_start = idle_base;
                     if (idle_hit) begin
                        nxt.mode         = psc_pkg::MODE_SLEEP;
                        res.action       = psc_pkg::ACT_OFF;
                        res.sleep_reason = psc_pkg::WHY_IDLE;
                     end
                  end
               end
            end
            psc_pkg::MODE_CHARGE: begin
               // switch is only sampled while USB is present
               if (!item.usb_present) begin
                  res.action = psc_pkg::ACT_RESET;
               end else begin
                  nxt.switch_off_armed = !item.switch_on;
                  nxt.switch_off_start = item.switch_on ? '0 : sw_base;
                  if (!sw_counts_on) begin
                     res.action = psc_pkg::ACT_RESET;
                  end
               end
            end
            psc_pkg::MODE_BATWAIT: begin
               if (item.switch_on) begin
                  res.action = psc_pkg::ACT_RESET;
               end
            end
            default: begin
               nxt = cur;
            end
         endcase
      end

      case (nxt.mode)
         psc_pkg::MODE_RUNNING: res.power_state = psc_pkg::STATE_RUN;
         psc_pkg::MODE_CHARGE:  res.power_state = psc_pkg::STATE_CHARGE;
         psc_pkg::MODE_BATWAIT: res.power_state = psc_pkg::STATE_BATWAIT;
         default:               res.power_state = psc_pkg::STATE_SLEEP;
      endcase
   end

endmodule
